/* design/ppeu_pkg.sv */
// Package for the particle pool emitter: codes, types and helper functions.
// It depends on nothing; the top level and the testbench use it.
package ppeu_pkg;

    localparam int POOL_SLOTS_DEF = 64;
    localparam logic [31:0] SEED = 32'h1234_5678;

    localparam logic [2:0] ACT_TICK   = 3'd0;
    localparam logic [2:0] ACT_BURST  = 3'd1;
    localparam logic [2:0] ACT_PLAY   = 3'd2;
    localparam logic [2:0] ACT_STOP   = 3'd3;
    localparam logic [2:0] ACT_PAUSE  = 3'd4;
    localparam logic [2:0] ACT_RESUME = 3'd5;
    localparam logic [2:0] ACT_CLEAR  = 3'd6;

    localparam logic [2:0] REG_INTERVAL = 3'd0;
    localparam logic [2:0] REG_LIMIT    = 3'd1;
    localparam logic [2:0] REG_START_V  = 3'd2;
    localparam logic [2:0] REG_SPREAD_V = 3'd3;
    localparam logic [2:0] REG_LIFE     = 3'd4;
    localparam logic [2:0] REG_GRAVITY  = 3'd5;
    localparam logic [2:0] REG_CENTER   = 3'd6;
    localparam logic [2:0] REG_SIZE     = 3'd7;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EMIT_CHK,
        ST_DRAW,
        ST_DRAW_WAIT,
        ST_EMIT_WR,
        ST_WALK_RD,
        ST_WALK_EVAL,
        ST_MUL,
        ST_ACC,
        ST_WALK_WR,
        ST_PUSH,
        ST_FLUSH
    } state_t;

    typedef struct packed {
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] vx;
        logic signed [31:0] vy;
        logic [15:0]        age;
        logic [15:0]        life;
    } entry_t;

    typedef struct packed {
        logic [5:0]  slot;
        logic [31:0] px;
        logic [31:0] py;
        logic [15:0] age;
        logic [15:0] life;
    } result_t;

    function automatic logic [31:0] xorshift(input logic [31:0] s);
        logic [31:0] x;
        begin
            x = s ^ (s << 13);
            x = x ^ (x >> 17);
            x = x ^ (x << 5);
            return x;
        end
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [49:0] v);
        begin
            if (v > 50'sh0_7FFF_FFFF)
                return 32'sh7FFF_FFFF;
            else if (v < -50'sh0_8000_0000)
                return -32'sh8000_0000;
            else
                return v[31:0];
        end
    endfunction

endpackage

/* design/ppeu_div.sv */
// Restoring remainder unit, one quotient bit per cycle; done rises after the last bit.
// Does not use ppeu_pkg; stands alone.
module ppeu_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] dividend,
    input  logic [16:0] divisor,
    output logic        busy,
    output logic        done,
    output logic [16:0] rem
);

    logic [17:0] rem_reg, rem_next;
    logic [31:0] num_reg;
    logic [16:0] den_reg;
    logic [5:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [17:0] trial;

    always_comb
    begin
        trial = {rem_reg[16:0], num_reg[31]};
        if (trial >= {1'b0, den_reg})
            rem_next = trial - {1'b0, den_reg};
        else
            rem_next = trial;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 6'd1;
                if (cnt_reg == 6'd31)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            num_reg <= dividend;
            den_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            num_reg <= {num_reg[30:0], 1'b0};
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign rem  = rem_reg[16:0];

endmodule

/* design/ppeu_mul.sv */
// Shared signed 32 by unsigned 16 multiplier with a registered product.
// Stands alone; used by the integration steps of the top level.
module ppeu_mul (
    input  logic               clk,
    input  logic signed [31:0] a,
    input  logic [15:0]        b,
    output logic signed [48:0] p
);

    logic signed [48:0] p_reg;

    always_ff @(posedge clk)
    begin
        p_reg <= a * $signed({1'b0, b});
    end

    assign p = p_reg;

endmodule

/* design/particle_pool_emit_update.sv */
// Top level of the particle pool: sequencer, pool memory and register file.
// Depends on ppeu_pkg, ppeu_div and ppeu_mul.
//
// Channel   Dir  Handshake          Contents
// s_*       in   s_tvalid/s_tready  action, time_step, burst_count
// m_*       out  m_tvalid/m_tready  slot, pos_x, pos_y, age, life, size; tlast
// cfg_*     in   cfg_valid/cfg_ready register index and data
//
// Tick or burst: accept state, then per new particle a check, three random
// draws (each a start and a wait state on the shared remainder unit) and a
// write state, then a last check. A tick then walks the pool: read and evaluate
// per slot; a survivor adds multiply and accumulate states for each of four
// products on the single multiplier, then write and push; read and flush end
// it. Other actions: accept state only. Reset is immediate; the pool needs no
// clearing. A stalled output word holds the walk until it is taken.
module particle_pool_emit_update #(
    parameter int POOL_SLOTS = ppeu_pkg::POOL_SLOTS_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // action [2:0], time_step [18:3], burst_count [25:19], zeros above
    input  logic [31:0]  s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // slot_index [5:0], pos_x [37:6], pos_y [69:38], age [85:70],
    // life_span [101:86], size [117:102], zeros above
    output logic [119:0] m_tdata,
    output logic         m_tlast,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [2:0]   cfg_index,
    input  logic [31:0]  cfg_data
);

    localparam int IW = (POOL_SLOTS > 1) ? $clog2(POOL_SLOTS) : 1;
    localparam int CW = $clog2(POOL_SLOTS + 1);

    ppeu_pkg::state_t state_reg, state_next;

    logic [15:0] interval_reg, size_reg;
    logic [6:0]  limit_cfg_reg;
    logic [31:0] startv_reg, spread_reg, life_cfg_reg, grav_reg, center_reg;

    logic [CW-1:0] live_reg, i_reg, w_reg, limit;
    logic [31:0]   acc_reg, rng_reg;
    logic          playing_reg, paused_reg, tick_reg;
    logic [15:0]   dt_reg;
    logic [6:0]    burst_reg;
    logic [1:0]    draw_reg, mul_reg;
    logic signed [18:0] off_reg [3];

    ppeu_pkg::entry_t mem [POOL_SLOTS];
    ppeu_pkg::entry_t rd_reg, work_reg, new_entry;
    ppeu_pkg::result_t pend_reg, out_reg;
    logic pend_valid_reg, out_valid_reg, out_last_reg;

    logic [2:0]  in_action;
    logic [15:0] in_dt;
    logic [6:0]  in_count;
    logic        in_fire, out_free, can_emit, out_load;
    logic [16:0] age_sum;
    logic [15:0] age_sat;
    logic [15:0] draw_spread;
    logic [31:0] rng_step;

    logic        div_start, div_busy, div_done;
    logic [16:0] div_rem;
    logic signed [31:0] mul_a;
    logic signed [48:0] mul_p;
    logic        mem_we, mem_re;
    logic [IW-1:0] mem_waddr;

    assign in_action = s_tdata[2:0];
    assign in_dt     = s_tdata[18:3];
    assign in_count  = s_tdata[25:19];
    assign in_fire   = s_tvalid && s_tready;
    assign out_free  = !out_valid_reg || m_tready;
    assign out_load  = pend_valid_reg && out_free
                    && (state_reg == ppeu_pkg::ST_PUSH || state_reg == ppeu_pkg::ST_FLUSH);
    assign cfg_ready = 1'b1;
    assign rng_step  = ppeu_pkg::xorshift(rng_reg);

    assign limit = (32'(limit_cfg_reg) > POOL_SLOTS) ? CW'(POOL_SLOTS)
                                                     : CW'(limit_cfg_reg);

    always_comb
    begin
        if (tick_reg)
            can_emit = playing_reg && !paused_reg
                    && (acc_reg >= {16'd0, interval_reg}) && (live_reg < limit);
        else
            can_emit = (burst_reg != 7'd0) && (live_reg < limit);
    end

    always_comb
    begin
        unique case (draw_reg)
            2'd0:    draw_spread = spread_reg[15:0];
            2'd1:    draw_spread = spread_reg[31:16];
            default: draw_spread = life_cfg_reg[31:16];
        endcase
    end

    assign age_sum = {1'b0, rd_reg.age} + {1'b0, dt_reg};
    assign age_sat = age_sum[16] ? 16'hFFFF : age_sum[15:0];

    always_comb
    begin
        logic signed [19:0] vx, vy, lf;
        vx = 20'(signed'(startv_reg[15:0])) + 20'(off_reg[0]);
        vy = 20'(signed'(startv_reg[31:16])) + 20'(off_reg[1]);
        lf = $signed({4'd0, life_cfg_reg[15:0]}) + 20'(off_reg[2]);
        new_entry.vx = 32'(vx) <<< 8;
        new_entry.vy = 32'(vy) <<< 8;
        new_entry.px = 32'(signed'(center_reg[15:0])) <<< 8;
        new_entry.py = 32'(signed'(center_reg[31:16])) <<< 8;
        new_entry.age = '0;
        if (lf < 0)
            new_entry.life = '0;
        else if (lf > 20'sd65535)
            new_entry.life = 16'hFFFF;
        else
            new_entry.life = lf[15:0];
    end

    always_comb
    begin
        unique case (mul_reg)
            2'd0:    mul_a = work_reg.vx;
            2'd1:    mul_a = work_reg.vy;
            2'd2:    mul_a = 32'(signed'(grav_reg[15:0]));
            default: mul_a = 32'(signed'(grav_reg[31:16]));
        endcase
    end

    ppeu_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (rng_step),
        .divisor  ({draw_spread, 1'b1}),
        .busy     (div_busy),
        .done     (div_done),
        .rem      (div_rem)
    );

    ppeu_mul u_mul (
        .clk (clk),
        .a   (mul_a),
        .b   (dt_reg),
        .p   (mul_p)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ppeu_pkg::ST_IDLE:
            begin
                if (in_fire && (in_action == ppeu_pkg::ACT_TICK
                                || in_action == ppeu_pkg::ACT_BURST))
                    state_next = ppeu_pkg::ST_EMIT_CHK;
            end
            ppeu_pkg::ST_EMIT_CHK:
            begin
                if (can_emit)
                    state_next = ppeu_pkg::ST_DRAW;
                else if (tick_reg)
                    state_next = ppeu_pkg::ST_WALK_RD;
                else
                    state_next = ppeu_pkg::ST_IDLE;
            end
            ppeu_pkg::ST_DRAW:      state_next = ppeu_pkg::ST_DRAW_WAIT;
            ppeu_pkg::ST_DRAW_WAIT:
            begin
                if (div_done)
                    state_next = (draw_reg == 2'd2) ? ppeu_pkg::ST_EMIT_WR
                                                    : ppeu_pkg::ST_DRAW;
            end
            ppeu_pkg::ST_EMIT_WR:   state_next = ppeu_pkg::ST_EMIT_CHK;
            ppeu_pkg::ST_WALK_RD:
            begin
                state_next = (i_reg == live_reg) ? ppeu_pkg::ST_FLUSH
                                                 : ppeu_pkg::ST_WALK_EVAL;
            end
            ppeu_pkg::ST_WALK_EVAL:
            begin
                state_next = (age_sat >= rd_reg.life) ? ppeu_pkg::ST_WALK_RD
                                                      : ppeu_pkg::ST_MUL;
            end
            ppeu_pkg::ST_MUL:       state_next = ppeu_pkg::ST_ACC;
            ppeu_pkg::ST_ACC:
            begin
                state_next = (mul_reg == 2'd3) ? ppeu_pkg::ST_WALK_WR
                                               : ppeu_pkg::ST_MUL;
            end
            ppeu_pkg::ST_WALK_WR:   state_next = ppeu_pkg::ST_PUSH;
            ppeu_pkg::ST_PUSH:
            begin
                if (!pend_valid_reg || out_free)
                    state_next = ppeu_pkg::ST_WALK_RD;
            end
            ppeu_pkg::ST_FLUSH:
            begin
                if (!pend_valid_reg || out_free)
                    state_next = ppeu_pkg::ST_IDLE;
            end
            default:                state_next = ppeu_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        s_tready  = (state_reg == ppeu_pkg::ST_IDLE);
        div_start = (state_reg == ppeu_pkg::ST_DRAW);
        mem_re    = (state_reg == ppeu_pkg::ST_WALK_RD);
        mem_we    = (state_reg == ppeu_pkg::ST_EMIT_WR)
                 || (state_reg == ppeu_pkg::ST_WALK_WR);
        mem_waddr = (state_reg == ppeu_pkg::ST_EMIT_WR) ? live_reg[IW-1:0]
                                                        : w_reg[IW-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= (state_reg == ppeu_pkg::ST_EMIT_WR) ? new_entry
                                                                  : work_reg;
        if (mem_re)
            rd_reg <= mem[i_reg[IW-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ppeu_pkg::ST_IDLE;
            interval_reg   <= 16'd256;
            limit_cfg_reg  <= 7'd64;
            startv_reg     <= '0;
            spread_reg     <= '0;
            life_cfg_reg   <= 32'd256;
            grav_reg       <= '0;
            center_reg     <= '0;
            size_reg       <= 16'd256;
            live_reg       <= '0;
            acc_reg        <= '0;
            rng_reg        <= ppeu_pkg::SEED;
            playing_reg    <= 1'b0;
            paused_reg     <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    ppeu_pkg::REG_INTERVAL: interval_reg  <= cfg_data[15:0];
                    ppeu_pkg::REG_LIMIT:    limit_cfg_reg <= cfg_data[6:0];
                    ppeu_pkg::REG_START_V:  startv_reg    <= cfg_data;
                    ppeu_pkg::REG_SPREAD_V: spread_reg    <= cfg_data;
                    ppeu_pkg::REG_LIFE:     life_cfg_reg  <= cfg_data;
                    ppeu_pkg::REG_GRAVITY:  grav_reg      <= cfg_data;
                    ppeu_pkg::REG_CENTER:   center_reg    <= cfg_data;
                    ppeu_pkg::REG_SIZE:     size_reg      <= cfg_data[15:0];
                endcase
            end
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                ppeu_pkg::ST_IDLE:
                begin
                    if (in_fire)
                    begin
                        unique case (in_action)
                            ppeu_pkg::ACT_TICK:
                            begin
                                if (playing_reg && !paused_reg)
                                begin
                                    logic [32:0] a;
                                    a = {1'b0, acc_reg} + {17'd0, in_dt};
                                    acc_reg <= a[32] ? 32'hFFFF_FFFF : a[31:0];
                                end
                            end
                            ppeu_pkg::ACT_PLAY:
                            begin
                                playing_reg <= 1'b1;
                                paused_reg  <= 1'b0;
                                acc_reg     <= '0;
                            end
                            ppeu_pkg::ACT_STOP:
                            begin
                                playing_reg <= 1'b0;
                                paused_reg  <= 1'b0;
                                acc_reg     <= '0;
                            end
                            ppeu_pkg::ACT_PAUSE:  paused_reg <= 1'b1;
                            ppeu_pkg::ACT_RESUME: paused_reg <= 1'b0;
                            ppeu_pkg::ACT_CLEAR:  live_reg   <= '0;
                            default: ;
                        endcase
                    end
                end
                ppeu_pkg::ST_EMIT_CHK:
                begin
                    if (can_emit && tick_reg)
                        acc_reg <= acc_reg - {16'd0, interval_reg};
                end
                ppeu_pkg::ST_DRAW:
                    rng_reg <= rng_step;
                ppeu_pkg::ST_EMIT_WR:
                    live_reg <= live_reg + CW'(1);
                ppeu_pkg::ST_FLUSH:
                begin
                    if (!pend_valid_reg || out_free)
                    begin
                        live_reg       <= w_reg;
                        pend_valid_reg <= 1'b0;
                    end
                end
                ppeu_pkg::ST_PUSH:
                    pend_valid_reg <= 1'b1;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ppeu_pkg::ST_IDLE:
            begin
                tick_reg  <= (in_action == ppeu_pkg::ACT_TICK);
                dt_reg    <= in_dt;
                burst_reg <= in_count;
                i_reg     <= '0;
                w_reg     <= '0;
            end
            ppeu_pkg::ST_EMIT_CHK:
            begin
                draw_reg <= 2'd0;
                if (can_emit && !tick_reg)
                    burst_reg <= burst_reg - 7'd1;
            end
            ppeu_pkg::ST_DRAW_WAIT:
            begin
                if (div_done)
                begin
                    off_reg[draw_reg] <= $signed({2'b0, div_rem})
                                       - $signed({3'b0, draw_spread});
                    draw_reg <= draw_reg + 2'd1;
                end
            end
            ppeu_pkg::ST_WALK_RD:
                i_reg <= i_reg + CW'(1);
            ppeu_pkg::ST_WALK_EVAL:
            begin
                work_reg <= {rd_reg.px, rd_reg.py, rd_reg.vx, rd_reg.vy,
                             age_sat, rd_reg.life};
                mul_reg  <= 2'd0;
            end
            ppeu_pkg::ST_ACC:
            begin
                unique case (mul_reg)
                    2'd0: work_reg.px <= ppeu_pkg::sat32(50'(work_reg.px)
                                                       + 50'(mul_p >>> 8));
                    2'd1: work_reg.py <= ppeu_pkg::sat32(50'(work_reg.py)
                                                       + 50'(mul_p >>> 8));
                    2'd2: work_reg.vx <= ppeu_pkg::sat32(50'(work_reg.vx)
                                                       + 50'(mul_p));
                    default: work_reg.vy <= ppeu_pkg::sat32(50'(work_reg.vy)
                                                          + 50'(mul_p));
                endcase
                mul_reg <= mul_reg + 2'd1;
            end
            ppeu_pkg::ST_PUSH:
            begin
                if (!pend_valid_reg || out_free)
                begin
                    if (pend_valid_reg)
                    begin
                        out_reg      <= pend_reg;
                        out_last_reg <= 1'b0;
                    end
                    pend_reg.slot <= 6'(w_reg);
                    pend_reg.px   <= work_reg.px;
                    pend_reg.py   <= work_reg.py;
                    pend_reg.age  <= work_reg.age;
                    pend_reg.life <= work_reg.life;
                    w_reg         <= w_reg + CW'(1);
                end
            end
            ppeu_pkg::ST_FLUSH:
            begin
                if (pend_valid_reg && out_free)
                begin
                    out_reg      <= pend_reg;
                    out_last_reg <= 1'b1;
                end
            end
            default: ;
        endcase
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {2'b00, size_reg, out_reg.life, out_reg.age,
                       out_reg.py, out_reg.px, out_reg.slot};

    a_live_bound: assert property (@(posedge clk) disable iff (!rst_n)
        live_reg <= CW'(POOL_SLOTS))
        else $error("live count above pool size");

    a_compact: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ppeu_pkg::ST_IDLE) |-> (w_reg <= i_reg))
        else $error("write pointer passed read pointer");

    a_div_use: assert property (@(posedge clk) disable iff (!rst_n)
        div_busy |-> (state_reg == ppeu_pkg::ST_DRAW_WAIT))
        else $error("remainder unit busy outside a draw");

endmodule

/* dv/tb_particle_pool_emit_update.sv */
// Testbench for particle_pool_emit_update: directed and random actions over
// several register settings, checked against an in-bench predictor of the pool.
// Depends on ppeu_pkg and the RTL of the block only.
module tb_particle_pool_emit_update;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS       = 64;
    localparam int IDLE_LIMIT  = 40000;
    localparam int SETTLE_WAIT = 7000;
    localparam logic [2:0] ACT_UNDEF = 3'd7;

    typedef struct {
        logic [5:0]  slot;
        logic [31:0] px;
        logic [31:0] py;
        logic [15:0] age;
        logic [15:0] life;
        logic [15:0] size;
        logic        last;
    } particle_word_t;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [31:0]  s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [119:0] m_tdata;
    logic         m_tlast;
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    logic [2:0]   cfg_index = '0;
    logic [31:0]  cfg_data = '0;

    particle_pool_emit_update u_top (.*);

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Predictor state
    logic [15:0]        interval_q;
    logic [6:0]         limit_q;
    logic [31:0]        start_v_q, spread_v_q, life_q, gravity_q, center_q;
    logic [15:0]        size_q;
    logic signed [31:0] pos_x_m [SLOTS];
    logic signed [31:0] pos_y_m [SLOTS];
    logic signed [31:0] vel_x_m [SLOTS];
    logic signed [31:0] vel_y_m [SLOTS];
    logic [15:0]        age_m [SLOTS];
    logic [15:0]        life_m [SLOTS];
    int unsigned        live_n;
    logic [31:0]        emit_acc;
    logic [31:0]        prng;
    bit                 playing_q, paused_q;

    particle_word_t particle_reports[$];
    int  err_count = 0;
    bit  calm = 1'b0;

    task automatic report(input string what, input longint got, input longint want);
        $display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $realtime);
        err_count++;
    endtask

    function automatic int half_s(input logic [15:0] h);
        return int'($signed(h));
    endfunction

    function automatic logic signed [31:0] clip32(input longint v);
        if (v > 64'sd2147483647)
            return 32'sh7FFF_FFFF;
        if (v < -64'sd2147483648)
            return 32'sh8000_0000;
        return v[31:0];
    endfunction

    function automatic longint spread_draw(input logic [15:0] s);
        logic [31:0] x;
        longint      m;
        x = prng;
        x = x ^ (x << 13);
        x = x ^ (x >> 17);
        x = x ^ (x << 5);
        prng = x;
        m = 2 * longint'(s) + 1;
        return (longint'(x) % m) - longint'(s);
    endfunction

    function automatic int unsigned pool_cap();
        return (limit_q > SLOTS) ? SLOTS : limit_q;
    endfunction

    function automatic void spawn_particle();
        longint vx, vy, lf;
        if (live_n >= SLOTS)
            return;
        vx = half_s(start_v_q[15:0]) + spread_draw(spread_v_q[15:0]);
        vy = half_s(start_v_q[31:16]) + spread_draw(spread_v_q[31:16]);
        lf = longint'(life_q[15:0]) + spread_draw(life_q[31:16]);
        if (lf < 0)
            lf = 0;
        if (lf > 65535)
            lf = 65535;
        vel_x_m[live_n] = 32'(vx * 256);
        vel_y_m[live_n] = 32'(vy * 256);
        pos_x_m[live_n] = half_s(center_q[15:0]) * 256;
        pos_y_m[live_n] = half_s(center_q[31:16]) * 256;
        age_m[live_n]   = '0;
        life_m[live_n]  = lf[15:0];
        live_n++;
    endfunction

    function automatic void advance_pool(input logic [2:0] act, input logic [15:0] dt,
                                         input logic [6:0] cnt);
        longint         a, gx, gy, dts;
        int unsigned    w, agev;
        particle_word_t r;
        dts = longint'(dt);
        case (act)
            ppeu_pkg::ACT_BURST:
            begin
                for (int i = 0; i < cnt && live_n < pool_cap(); i++)
                    spawn_particle();
                return;
            end
            ppeu_pkg::ACT_PLAY:
            begin
                playing_q = 1'b1; paused_q = 1'b0; emit_acc = '0;
                return;
            end
            ppeu_pkg::ACT_STOP:
            begin
                playing_q = 1'b0; paused_q = 1'b0; emit_acc = '0;
                return;
            end
            ppeu_pkg::ACT_PAUSE:  begin paused_q = 1'b1; return; end
            ppeu_pkg::ACT_RESUME: begin paused_q = 1'b0; return; end
            ppeu_pkg::ACT_CLEAR:  begin live_n = 0; return; end
            ppeu_pkg::ACT_TICK:   ;
            default:    return;
        endcase
        if (playing_q && !paused_q)
        begin
            a = longint'(emit_acc) + dts;
            emit_acc = (a > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : a[31:0];
            while (emit_acc >= interval_q && live_n < pool_cap())
            begin
                emit_acc -= interval_q;
                spawn_particle();
            end
        end
        gx = half_s(gravity_q[15:0]);
        gy = half_s(gravity_q[31:16]);
        w = 0;
        for (int i = 0; i < live_n; i++)
        begin
            agev = age_m[i] + dt;
            if (agev > 65535)
                agev = 65535;
            if (agev >= life_m[i])
                continue;
            pos_x_m[w] = clip32(longint'(pos_x_m[i]) + ((longint'(vel_x_m[i]) * dts) >>> 8));
            pos_y_m[w] = clip32(longint'(pos_y_m[i]) + ((longint'(vel_y_m[i]) * dts) >>> 8));
            vel_x_m[w] = clip32(longint'(vel_x_m[i]) + gx * dts);
            vel_y_m[w] = clip32(longint'(vel_y_m[i]) + gy * dts);
            age_m[w]   = agev[15:0];
            life_m[w]  = life_m[i];
            w++;
        end
        live_n = w;
        for (int i = 0; i < w; i++)
        begin
            r.slot = i[5:0];
            r.px   = pos_x_m[i];
            r.py   = pos_y_m[i];
            r.age  = age_m[i];
            r.life = life_m[i];
            r.size = size_q;
            r.last = (i + 1 == w);
            particle_reports = {particle_reports, r};
        end
    endfunction

    task automatic send_word(input logic [2:0] act, input logic [15:0] dt,
                             input logic [6:0] cnt);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 17);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tdata  <= {6'd0, cnt, dt, act};
        s_tvalid <= 1'b1;
        do @(posedge clk); while (!s_tready);
        advance_pool(act, dt, cnt);
    endtask

    task automatic drain_pool();
        s_tvalid <= 1'b0;
        while (particle_reports.size() != 0)
            @(posedge clk);
        repeat (SETTLE_WAIT) @(posedge clk);
    endtask

    task automatic write_regs(input logic [31:0] v [8]);
        for (int i = 0; i < 8; i++)
        begin
            cfg_index <= i[2:0];
            cfg_data  <= v[i];
            cfg_valid <= 1'b1;
            do @(posedge clk); while (!cfg_ready);
            case (i[2:0])
                ppeu_pkg::REG_INTERVAL: interval_q = v[i][15:0];
                ppeu_pkg::REG_LIMIT:    limit_q    = v[i][6:0];
                ppeu_pkg::REG_START_V:  start_v_q  = v[i];
                ppeu_pkg::REG_SPREAD_V: spread_v_q = v[i];
                ppeu_pkg::REG_LIFE:     life_q     = v[i];
                ppeu_pkg::REG_GRAVITY:  gravity_q  = v[i];
                ppeu_pkg::REG_CENTER:   center_q   = v[i];
                ppeu_pkg::REG_SIZE:     size_q     = v[i][15:0];
                default: ;
            endcase
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic send_random_word();
        int          pick;
        logic [2:0]  act;
        logic [15:0] dt;
        logic [6:0]  cnt;
        pick = $urandom_range(0, 99);
        dt   = ($urandom_range(0, 19) == 0) ? 16'($urandom_range(0, 65535))
                                            : 16'($urandom_range(0, 96));
        cnt  = ($urandom_range(0, 15) == 0) ? 7'd64 : 7'($urandom_range(0, 8));
        if (pick < 60)      act = ppeu_pkg::ACT_TICK;
        else if (pick < 76) act = ppeu_pkg::ACT_BURST;
        else if (pick < 82) act = ppeu_pkg::ACT_PLAY;
        else if (pick < 86) act = ppeu_pkg::ACT_PAUSE;
        else if (pick < 91) act = ppeu_pkg::ACT_RESUME;
        else if (pick < 94) act = ppeu_pkg::ACT_STOP;
        else if (pick < 97) act = ppeu_pkg::ACT_CLEAR;
        else                act = ACT_UNDEF;
        send_word(act, dt, cnt);
    endtask

    task automatic run_random(input int n);
        for (int i = 0; i < n; i++)
        begin
            if (i % 40 == 0)
                calm = ($urandom_range(0, 3) == 0);
            send_random_word();
        end
        calm = 1'b0;
    endtask

    task automatic test_defaults();
        send_word(ppeu_pkg::ACT_TICK, 16'd40, 7'd0);
        send_word(ppeu_pkg::ACT_BURST, 16'd0, 7'd3);
        send_word(ppeu_pkg::ACT_TICK, 16'd10, 7'd0);
        send_word(ppeu_pkg::ACT_PLAY, 16'd0, 7'd0);
        send_word(ppeu_pkg::ACT_TICK, 16'd0, 7'd0);
        send_word(ppeu_pkg::ACT_TICK, 16'd255, 7'd0);
        send_word(ppeu_pkg::ACT_TICK, 16'd1, 7'd0);
    endtask

    task automatic test_actions();
        send_word(ppeu_pkg::ACT_PAUSE, 16'hFFFF, 7'd127);
        send_word(ppeu_pkg::ACT_TICK, 16'd200, 7'd0);
        send_word(ppeu_pkg::ACT_RESUME, 16'd0, 7'd0);
        send_word(ppeu_pkg::ACT_TICK, 16'd200, 7'd0);
        send_word(ACT_UNDEF, 16'hFFFF, 7'd64);
        send_word(ppeu_pkg::ACT_BURST, 16'd0, 7'd64);
        send_word(ppeu_pkg::ACT_TICK, 16'd1, 7'd0);
        send_word(ppeu_pkg::ACT_BURST, 16'd0, 7'd5);
        send_word(ppeu_pkg::ACT_TICK, 16'hFFFF, 7'd0);
        send_word(ppeu_pkg::ACT_BURST, 16'd0, 7'd4);
        send_word(ppeu_pkg::ACT_CLEAR, 16'd0, 7'd0);
        send_word(ppeu_pkg::ACT_TICK, 16'd3, 7'd0);
        send_word(ppeu_pkg::ACT_STOP, 16'd0, 7'd0);
        send_word(ppeu_pkg::ACT_TICK, 16'd900, 7'd0);
        send_word(ppeu_pkg::ACT_BURST, 16'h5555, 7'd42);
        send_word(ppeu_pkg::ACT_TICK, 16'hAAAA, 7'd21);
    endtask

    task automatic test_phase(input logic [31:0] v [8], input int n);
        drain_pool();
        write_regs(v);
        send_word(ppeu_pkg::ACT_PLAY, 16'd0, 7'd0);
        run_random(n);
    endtask

    task automatic test_settings();
        test_phase('{16'd0, 7'd6, 32'h0100_FF00, 32'h0080_0040, 32'h0100_0200,
                     32'h0010_FFF0, 32'h7FFF_8000, 16'hFFFF}, 60);
        test_phase('{16'hFFFF, 7'd0, 32'h8000_7FFF, 32'h0000_0000, 32'h0000_0000,
                     32'h8000_7FFF, 32'h8000_7FFF, 16'd0}, 20);
        test_phase('{16'd96, 7'd100, 32'h7FFF_8000, 32'hFFFF_FFFF, 32'hFFFF_0300,
                     32'h7FFF_8000, 32'h0000_0000, 16'h1234}, 60);
        test_phase('{16'd40, 7'd20, 32'hFFE0_0020, 32'h0010_0010, 32'h0040_FFFF,
                     32'h0003_FFFD, 32'h00C0_FF40, 16'd256}, 60);
        // Shrink the limit below the live count while particles stay alive.
        send_word(ppeu_pkg::ACT_BURST, 16'd0, 7'd20);
        drain_pool();
        write_regs('{16'd1, 7'd4, 32'h0000_0000, 32'h0000_0000, 32'h0000_FFFF,
                     32'h0000_0000, 32'h0000_0000, 16'd256});
        send_word(ppeu_pkg::ACT_TICK, 16'd2, 7'd0);
        send_word(ppeu_pkg::ACT_BURST, 16'd0, 7'd3);
        send_word(ppeu_pkg::ACT_TICK, 16'd2, 7'd0);
        drain_pool();
        write_regs('{16'd256, 7'd64, 32'h0000_0000, 32'h0010_0010, 32'h0020_0140,
                     32'h0000_0000, 32'h0000_0000, 16'd256});
        send_word(ppeu_pkg::ACT_CLEAR, 16'd0, 7'd0);
        send_word(ppeu_pkg::ACT_PLAY, 16'd0, 7'd0);
        run_random(70);
        drain_pool();
        send_word(ppeu_pkg::ACT_BURST, 16'd0, 7'd6);
        run_random(105);
    endtask

    always @(posedge clk)
    begin
        particle_word_t e;
        if (m_tvalid && m_tready)
        begin
            if (particle_reports.size() == 0)
                report("unexpected word", m_tdata[5:0], 0);
            else
            begin
                e = particle_reports.pop_front();
                if (m_tdata[5:0] !== e.slot)      report("slot_index", m_tdata[5:0], e.slot);
                if (m_tdata[37:6] !== e.px)       report("pos_x", m_tdata[37:6], e.px);
                if (m_tdata[69:38] !== e.py)      report("pos_y", m_tdata[69:38], e.py);
                if (m_tdata[85:70] !== e.age)     report("age", m_tdata[85:70], e.age);
                if (m_tdata[101:86] !== e.life)   report("life_span", m_tdata[101:86], e.life);
                if (m_tdata[117:102] !== e.size)  report("size", m_tdata[117:102], e.size);
                if (m_tlast !== e.last)           report("last", m_tlast, e.last);
            end
        end
    end

    initial
    begin
        int n;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            n = calm ? 0 : $urandom_range(0, 17);
            if (n > 0)
            begin
                m_tready <= 1'b0;
                repeat (n) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!(m_tvalid && m_tready));
        end
    end

    initial
    begin
        int idle;
        idle = 0;
        forever
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                idle = 0;
            else
                idle++;
            if (idle >= IDLE_LIMIT)
            begin
                $display("tb_particle_pool_emit_update: done, errors");
                $finish;
            end
        end
    end

    initial
    begin
        interval_q = 16'd256; limit_q = 7'd64; start_v_q = '0; spread_v_q = '0;
        life_q = 32'd256; gravity_q = '0; center_q = '0; size_q = 16'd256;
        live_n = 0; emit_acc = '0; prng = ppeu_pkg::SEED;
        playing_q = 1'b0; paused_q = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_defaults();
        test_actions();
        test_settings();
        drain_pool();
        if (err_count == 0)
            $display("tb_particle_pool_emit_update: done, clean");
        else
            $display("tb_particle_pool_emit_update: done, errors");
        $finish;
    end

endmodule

/* filelist.f */
design/ppeu_pkg.sv
design/ppeu_div.sv
design/ppeu_mul.sv
design/particle_pool_emit_update.sv
dv/tb_particle_pool_emit_update.sv
